### hw/rtl/tce_pkg.sv
package tce_pkg;

  localparam int unsigned MAX_PAYLOAD = 1460;
  localparam logic [31:0] ISN_STEP = 32'h0000_1000;
  localparam logic [31:0] ISN_RESET = 32'hDEAD_0000;
  localparam logic [10:0] MIN_HDR_BYTES = 11'd20;
  localparam logic [15:0] WINDOW_RESET = 16'd8192;

  localparam logic [5:0] FL_NONE = 6'h00;
  localparam logic [5:0] FL_FIN = 6'h01;
  localparam logic [5:0] FL_SYN = 6'h02;
  localparam logic [5:0] FL_PSH = 6'h08;
  localparam logic [5:0] FL_ACK = 6'h10;

  localparam logic [1:0] CFG_OWN_PORT = 2'd0;
  localparam logic [1:0] CFG_PEER_PORT = 2'd1;
  localparam logic [1:0] CFG_RECEIVE_WINDOW = 2'd2;

  typedef enum logic [1:0] {
    ST_CLOSED      = 2'd0,
    ST_SYN_SENT    = 2'd1,
    ST_ESTABLISHED = 2'd2,
    ST_FIN_WAIT_1  = 2'd3
  } conn_state_t;

  typedef enum logic [2:0] {
    ACT_OPEN     = 3'd0,
    ACT_SEND_SYN = 3'd1,
    ACT_RECEIVE  = 3'd2,
    ACT_SEND_DATA = 3'd3,
    ACT_SEND_FIN = 3'd4,
    ACT_SEND_ACK = 3'd5
  } action_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] rx_src_port;
    logic [15:0] rx_dst_port;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [5:0]  rx_flags;
    logic [3:0]  rx_hdr_words;
    logic [10:0] rx_seg_len;
    logic [15:0] send_len;
  } evt_item_t;

  typedef struct packed {
    logic        segment_valid;
    logic [31:0] tx_seq;
    logic [31:0] tx_ack;
    logic [5:0]  tx_flags;
    logic [15:0] tx_window;
    logic [10:0] tx_payload_len;
    logic [1:0]  conn_state;
  } seg_item_t;

  typedef struct packed {
    logic [15:0] own_port;
    logic [15:0] peer_port;
    logic [15:0] receive_window;
  } cfg_t;

endpackage

### hw/rtl/tcp_client_connection_engine.sv
// Client-side TCP control block for an active open. Each accepted event waits in the input
// register and yields exactly one result item in the output register, which lets the next
// event enter while a result waits downstream. One event is taken every cycle unless a
// stalled result fills both registers; the connection state, send-next, receive-next and ISN
// counter update per event. Ports and window are written through the cfg channel, always ready.
module tcp_client_connection_engine
  import tce_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        evt_valid,
  output logic        evt_stall,
  input  evt_item_t   evt,
  output logic        seg_valid,
  input  logic        seg_stall,
  output seg_item_t   seg,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t      cfg;
  evt_item_t held;
  seg_item_t result;
  logic      full;
  logic      space;
  logic      advance;

  assign cfg_ready = 1'b1;
  assign advance = full && space;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.own_port <= 16'd0;
      cfg.peer_port <= 16'd0;
      cfg.receive_window <= WINDOW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_PORT: cfg.own_port <= cfg_data;
        CFG_PEER_PORT: cfg.peer_port <= cfg_data;
        CFG_RECEIVE_WINDOW: cfg.receive_window <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  tce_in_reg u_in (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt_valid),
    .evt_stall (evt_stall),
    .evt       (evt),
    .advance   (advance),
    .full      (full),
    .held      (held)
  );

  tce_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .evt     (held),
    .cfg     (cfg),
    .result  (result)
  );

  tce_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .d         (result),
    .space     (space),
    .seg_valid (seg_valid),
    .seg_stall (seg_stall),
    .seg       (seg)
  );

endmodule

### hw/rtl/tce_in_reg.sv
module tce_in_reg
  import tce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      evt_valid,
  output logic      evt_stall,
  input  evt_item_t evt,
  input  logic      advance,
  output logic      full,
  output evt_item_t held
);

  logic full_next;
  logic take;

  assign evt_stall = full && !advance;
  assign take = evt_valid && !evt_stall;

  always_comb begin
    if (take) begin
      full_next = 1'b1;
    end else if (advance) begin
      full_next = 1'b0;
    end else begin
      full_next = full;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else begin
      full <= full_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      held <= evt;
    end
  end

endmodule

### hw/rtl/tce_core.sv
module tce_core
  import tce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      advance,
  input  evt_item_t evt,
  input  cfg_t      cfg,
  output seg_item_t result
);

  conn_state_t state;
  conn_state_t state_next;
  logic [31:0] send_next;
  logic [31:0] send_next_next;
  logic [31:0] receive_next;
  logic [31:0] receive_next_next;
  logic [31:0] isn_counter;
  logic [31:0] isn_counter_next;

  logic        rx_ok;
  logic        data_ok;
  logic [10:0] hdr_bytes;
  logic        emit;
  logic [5:0]  flags;
  logic [10:0] plen;

  always_comb begin
    hdr_bytes = {5'b0, evt.rx_hdr_words, 2'b00};
    rx_ok = (state == ST_SYN_SENT) &&
            (evt.rx_seg_len >= MIN_HDR_BYTES) &&
            (hdr_bytes >= MIN_HDR_BYTES) &&
            (hdr_bytes <= evt.rx_seg_len) &&
            ((evt.rx_flags & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK)) &&
            (evt.rx_dst_port == cfg.own_port) &&
            (evt.rx_src_port == cfg.peer_port) &&
            (evt.rx_ack == send_next);
    data_ok = (state == ST_ESTABLISHED) && (evt.send_len != 16'd0) &&
              (evt.send_len <= 16'(MAX_PAYLOAD));
  end

  always_comb begin
    state_next = state;
    unique case (evt.action)
      ACT_OPEN: state_next = ST_CLOSED;
      ACT_SEND_SYN: begin
        if (state == ST_CLOSED) begin
          state_next = ST_SYN_SENT;
        end
      end
      ACT_RECEIVE: begin
        if (rx_ok) begin
          state_next = ST_ESTABLISHED;
        end
      end
      ACT_SEND_FIN: begin
        if (state == ST_ESTABLISHED) begin
          state_next = ST_FIN_WAIT_1;
        end
      end
      default: state_next = state;
    endcase
  end

  always_comb begin
    emit = 1'b0;
    flags = FL_NONE;
    plen = 11'd0;
    send_next_next = send_next;
    receive_next_next = receive_next;
    isn_counter_next = isn_counter;
    unique case (evt.action)
      ACT_OPEN: begin
        send_next_next = isn_counter;
        isn_counter_next = isn_counter + ISN_STEP;
        receive_next_next = 32'd0;
      end
      ACT_SEND_SYN: begin
        if (state == ST_CLOSED) begin
          emit = 1'b1;
          flags = FL_SYN;
          send_next_next = send_next + 32'd1;
        end
      end
      ACT_RECEIVE: begin
        if (rx_ok) begin
          emit = 1'b1;
          flags = FL_ACK;
          receive_next_next = evt.rx_seq + 32'd1;
        end
      end
      ACT_SEND_DATA: begin
        if (data_ok) begin
          emit = 1'b1;
          flags = FL_PSH | FL_ACK;
          plen = evt.send_len[10:0];
          send_next_next = send_next + {16'b0, evt.send_len};
        end
      end
      ACT_SEND_FIN: begin
        if (state == ST_ESTABLISHED) begin
          emit = 1'b1;
          flags = FL_FIN | FL_ACK;
          send_next_next = send_next + 32'd1;
        end
      end
      ACT_SEND_ACK: begin
        if (state == ST_ESTABLISHED || state == ST_FIN_WAIT_1) begin
          emit = 1'b1;
          flags = FL_ACK;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_comb begin
    result = '0;
    result.conn_state = state_next;
    if (emit) begin
      result.segment_valid = 1'b1;
      result.tx_seq = send_next;
      result.tx_ack = ((flags & FL_ACK) != FL_NONE) ? receive_next_next : 32'd0;
      result.tx_flags = flags;
      result.tx_window = cfg.receive_window;
      result.tx_payload_len = plen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLOSED;
      send_next <= 32'd0;
      receive_next <= 32'd0;
      isn_counter <= ISN_RESET;
    end else if (advance) begin
      state <= state_next;
      send_next <= send_next_next;
      receive_next <= receive_next_next;
      isn_counter <= isn_counter_next;
    end
  end

endmodule

### hw/rtl/tce_out_reg.sv
module tce_out_reg
  import tce_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  seg_item_t d,
  output logic      space,
  output logic      seg_valid,
  input  logic      seg_stall,
  output seg_item_t seg
);

  logic seg_valid_next;

  assign space = !seg_valid || !seg_stall;

  always_comb begin
    if (load) begin
      seg_valid_next = 1'b1;
    end else if (seg_valid && !seg_stall) begin
      seg_valid_next = 1'b0;
    end else begin
      seg_valid_next = seg_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_valid <= 1'b0;
    end else begin
      seg_valid <= seg_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      seg <= d;
    end
  end

endmodule

### hw/rtl/tce_checker.sv
module tce_checker
  import tce_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        evt_stall,
  input logic        seg_valid,
  input logic        seg_stall,
  input seg_item_t   seg
);

  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_stall |=> seg_valid && $stable(seg))
    else $error("result item changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !seg_valid && !evt_stall)
    else $error("pipeline not empty after reset");

  a_no_segment_zero: assert property (@(posedge clk) disable iff (rst)
    seg_valid && !seg.segment_valid |->
      seg.tx_seq == 32'd0 && seg.tx_ack == 32'd0 && seg.tx_flags == FL_NONE &&
      seg.tx_window == 16'd0 && seg.tx_payload_len == 11'd0)
    else $error("segment fields set without a segment");

  a_syn_state: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg.segment_valid && seg.tx_flags == FL_SYN |->
      seg.conn_state == ST_SYN_SENT && seg.tx_payload_len == 11'd0 &&
      seg.tx_ack == 32'd0)
    else $error("syn item with wrong state or fields");

endmodule

bind tcp_client_connection_engine tce_checker u_tce_checker (.*);

### test/tcp_client_connection_engine_test.sv
`timescale 1ns / 1ps

module tcp_client_connection_engine_test;
  import tce_pkg::*;

  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;
  localparam int PHASES = 6;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int HOLD_CYCLES = 90;

  typedef struct {
    evt_item_t ev;
    bit        typed;
    seg_item_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        evt_valid = 1'b0;
  logic        evt_stall;
  evt_item_t   evt = '0;
  logic        seg_valid;
  logic        seg_stall = 1'b0;
  seg_item_t   seg;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // predictor state
  conn_state_t link_state = ST_CLOSED;
  logic [31:0] snd_nxt = '0;
  logic [31:0] rcv_nxt = '0;
  logic [31:0] isn_ctr = ISN_RESET;
  cfg_t        port_cfg = '{16'd0, 16'd0, WINDOW_RESET};

  seg_item_t   expected_segs [$];
  stim_row_t   directed_rows [$];
  int          mismatches = 0;
  int          gap_pct = 15;
  int          stall_pct = 15;
  bit          hold_request = 1'b0;
  int          gap_plan [PHASES] = '{20, 0, 35, 10, 25, 0};
  int          stall_plan [PHASES] = '{20, 0, 10, 35, 25, 0};

  tcp_client_connection_engine DUT (
    .clk(clk),
    .rst(rst),
    .evt_valid(evt_valid),
    .evt_stall(evt_stall),
    .evt(evt),
    .seg_valid(seg_valid),
    .seg_stall(seg_stall),
    .seg(seg),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic seg_item_t predict_segment(input evt_item_t e);
    seg_item_t   s;
    logic        emits;
    logic [5:0]  flags;
    logic [31:0] advance;
    logic [10:0] plen;
    logic [10:0] hdr_bytes;
    s = '0;
    emits = 1'b0;
    flags = FL_NONE;
    advance = '0;
    plen = '0;
    hdr_bytes = {5'd0, e.rx_hdr_words, 2'b00};
    case (e.action)
      ACT_OPEN: begin
        snd_nxt = isn_ctr;
        isn_ctr = isn_ctr + ISN_STEP;
        rcv_nxt = '0;
        link_state = ST_CLOSED;
      end
      ACT_SEND_SYN: if (link_state == ST_CLOSED) begin
        emits = 1'b1;
        flags = FL_SYN;
        advance = 32'd1;
        link_state = ST_SYN_SENT;
      end
      ACT_RECEIVE: if (link_state == ST_SYN_SENT && e.rx_seg_len >= MIN_HDR_BYTES &&
                       hdr_bytes >= MIN_HDR_BYTES && hdr_bytes <= e.rx_seg_len &&
                       (e.rx_flags & (FL_SYN | FL_ACK)) == (FL_SYN | FL_ACK) &&
                       e.rx_dst_port == port_cfg.own_port &&
                       e.rx_src_port == port_cfg.peer_port && e.rx_ack == snd_nxt) begin
        rcv_nxt = e.rx_seq + 32'd1;
        emits = 1'b1;
        flags = FL_ACK;
        link_state = ST_ESTABLISHED;
      end
      ACT_SEND_DATA: if (link_state == ST_ESTABLISHED && e.send_len != 0 &&
                         e.send_len <= MAX_PAYLOAD) begin
        emits = 1'b1;
        flags = FL_PSH | FL_ACK;
        plen = e.send_len[10:0];
        advance = {16'd0, e.send_len};
      end
      ACT_SEND_FIN: if (link_state == ST_ESTABLISHED) begin
        emits = 1'b1;
        flags = FL_FIN | FL_ACK;
        advance = 32'd1;
        link_state = ST_FIN_WAIT_1;
      end
      ACT_SEND_ACK: if (link_state == ST_ESTABLISHED || link_state == ST_FIN_WAIT_1) begin
        emits = 1'b1;
        flags = FL_ACK;
      end
      default: ;
    endcase
    if (emits) begin
      s.segment_valid = 1'b1;
      s.tx_seq = snd_nxt;
      s.tx_ack = ((flags & FL_ACK) != 0) ? rcv_nxt : '0;
      s.tx_flags = flags;
      s.tx_window = port_cfg.receive_window;
      s.tx_payload_len = plen;
      snd_nxt = snd_nxt + advance;
    end
    s.conn_state = link_state;
    return s;
  endfunction

  function automatic evt_item_t make_event(input logic [2:0] act, input logic [15:0] dlen);
    evt_item_t e;
    e = '0;
    e.action = act;
    e.send_len = dlen;
    return e;
  endfunction

  function automatic evt_item_t make_rx(input logic [15:0] src, input logic [15:0] dst,
                                        input logic [31:0] seq, input logic [31:0] ack,
                                        input logic [5:0] flags, input logic [3:0] hw,
                                        input logic [10:0] len);
    evt_item_t e;
    e = '0;
    e.action = ACT_RECEIVE;
    e.rx_src_port = src;
    e.rx_dst_port = dst;
    e.rx_seq = seq;
    e.rx_ack = ack;
    e.rx_flags = flags;
    e.rx_hdr_words = hw;
    e.rx_seg_len = len;
    return e;
  endfunction

  function automatic seg_item_t no_segment(input conn_state_t st);
    seg_item_t s;
    s = '0;
    s.conn_state = st;
    return s;
  endfunction

  function automatic void add_row(input evt_item_t e, input bit typed, input seg_item_t want);
    stim_row_t r;
    r.ev = e;
    r.typed = typed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  // mostly well-formed handshakes and transfers, the rest noise and broken segments
  function automatic evt_item_t draw_event();
    evt_item_t e;
    int        pick;
    int        sub;
    e.action = 3'($urandom_range(0, 7));
    e.rx_src_port = 16'($urandom);
    e.rx_dst_port = 16'($urandom);
    e.rx_seq = $urandom;
    e.rx_ack = $urandom;
    e.rx_flags = 6'($urandom);
    e.rx_hdr_words = 4'($urandom);
    e.rx_seg_len = 11'($urandom);
    e.send_len = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) return e;
    if (pick < 19) begin
      e.action = ACT_OPEN;
      return e;
    end
    sub = $urandom_range(0, 99);
    case (link_state)
      ST_CLOSED: e.action = ACT_SEND_SYN;
      ST_SYN_SENT: begin
        e.action = ACT_RECEIVE;
        e.rx_src_port = port_cfg.peer_port;
        e.rx_dst_port = port_cfg.own_port;
        e.rx_ack = snd_nxt;
        e.rx_flags = e.rx_flags | FL_SYN | FL_ACK;
        e.rx_hdr_words = 4'($urandom_range(5, 15));
        e.rx_seg_len = 11'($urandom_range(e.rx_hdr_words * 4, 1480));
        if (sub < 25) begin
          case ($urandom_range(0, 6))
            0: e.rx_hdr_words = 4'($urandom_range(0, 4));
            1: e.rx_seg_len = 11'($urandom_range(0, 19));
            2: e.rx_seg_len = {5'd0, e.rx_hdr_words, 2'b00} - 11'd1;
            3: e.rx_flags = e.rx_flags & ~($urandom_range(0, 1) ? FL_SYN : FL_ACK);
            4: e.rx_dst_port = e.rx_dst_port ^ 16'($urandom_range(1, 65535));
            5: e.rx_src_port = e.rx_src_port ^ 16'($urandom_range(1, 65535));
            default: e.rx_ack = e.rx_ack ^ (32'd1 << $urandom_range(0, 31));
          endcase
        end
      end
      ST_ESTABLISHED: begin
        if (sub < 70) begin
          e.action = ACT_SEND_DATA;
          if ($urandom_range(0, 9) != 0) e.send_len = 16'($urandom_range(1, MAX_PAYLOAD));
        end else if (sub < 88) begin
          e.action = ACT_SEND_ACK;
        end else begin
          e.action = ACT_SEND_FIN;
        end
      end
      default: e.action = (sub < 70) ? ACT_SEND_ACK : ACT_OPEN;
    endcase
    return e;
  endfunction

  task automatic send_event(input evt_item_t e, input bit typed, input seg_item_t want);
    seg_item_t predicted;
    if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
      evt_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    evt_valid <= 1'b1;
    evt <= e;
    do @(posedge clk); while (evt_stall);
    predicted = predict_segment(e);
    expected_segs.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_config(input cfg_t c);
    logic [1:0]  idx [3];
    logic [15:0] vals [3];
    idx = '{CFG_OWN_PORT, CFG_PEER_PORT, CFG_RECEIVE_WINDOW};
    vals = '{c.own_port, c.peer_port, c.receive_window};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      @(negedge clk);
    end
    cfg_valid <= 1'b0;
    port_cfg = c;
  endtask

  task automatic wait_drained();
    evt_valid <= 1'b0;
    while (expected_segs.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    seg_item_t want;
    if (!rst && seg_valid && !seg_stall) begin
      if (expected_segs.size() == 0) begin
        $error("segment item with nothing expected: %h", seg);
        mismatches++;
      end else begin
        want = expected_segs.pop_front();
        check_field("segment_valid", 32'(want.segment_valid), 32'(seg.segment_valid));
        check_field("tx_seq", want.tx_seq, seg.tx_seq);
        check_field("tx_ack", want.tx_ack, seg.tx_ack);
        check_field("tx_flags", 32'(want.tx_flags), 32'(seg.tx_flags));
        check_field("tx_window", 32'(want.tx_window), 32'(seg.tx_window));
        check_field("tx_payload_len", 32'(want.tx_payload_len), 32'(seg.tx_payload_len));
        check_field("conn_state", 32'(want.conn_state), 32'(seg.conn_state));
      end
    end
  end

  // downstream stall bursts, plus one long hold to back the block up
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        burst = HOLD_CYCLES;
      end else if (burst == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        burst = $urandom_range(1, 18);
      end
      seg_stall <= (burst > 0);
      if (burst > 0) burst--;
    end
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cfg_t setting;
    add_row(make_event(ACT_SEND_SYN, 16'd0), 1'b1,
            '{1'b1, 32'd0, 32'd0, FL_SYN, WINDOW_RESET, 11'd0, ST_SYN_SENT});
    add_row(make_event(ACT_SEND_DATA, 16'd100), 1'b1, no_segment(ST_SYN_SENT));
    // malformed or foreign syn-ack
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd1, FL_SYN | FL_ACK, 4'd4, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd1, FL_SYN | FL_ACK, 4'd5, 11'd19), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd1, FL_SYN | FL_ACK, 4'd15, 11'd59), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd1, FL_SYN, 4'd5, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd1, FL_ACK, 4'd5, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd1, 32'd7, 32'd1, FL_SYN | FL_ACK, 4'd5, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'hFFFF, 16'd0, 32'd7, 32'd1, FL_SYN | FL_ACK, 4'd5, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    add_row(make_rx(16'd0, 16'd0, 32'd7, 32'd0, FL_SYN | FL_ACK, 4'd5, 11'd20), 1'b1,
            no_segment(ST_SYN_SENT));
    // all flags, largest header, a 1480-byte segment, receive-next wraps to zero
    add_row(make_rx(16'd0, 16'd0, 32'hFFFF_FFFF, 32'd1, 6'h3F, 4'd15, 11'd1480), 1'b1,
            '{1'b1, 32'd1, 32'd0, FL_ACK, WINDOW_RESET, 11'd0, ST_ESTABLISHED});
    add_row(make_event(ACT_SEND_DATA, 16'd0), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_SEND_DATA, 16'd1461), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_SEND_DATA, 16'hFFFF), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_SEND_DATA, 16'd1460), 1'b1,
            '{1'b1, 32'd1, 32'd0, FL_PSH | FL_ACK, WINDOW_RESET, 11'd1460, ST_ESTABLISHED});
    add_row(make_event(ACT_SEND_DATA, 16'd1), 1'b1,
            '{1'b1, 32'd1461, 32'd0, FL_PSH | FL_ACK, WINDOW_RESET, 11'd1, ST_ESTABLISHED});
    add_row(make_event(ACT_SEND_ACK, 16'd0), 1'b1,
            '{1'b1, 32'd1462, 32'd0, FL_ACK, WINDOW_RESET, 11'd0, ST_ESTABLISHED});
    add_row(make_event(ACT_UNUSED_6, 16'd5), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_UNUSED_7, 16'd5), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_SEND_SYN, 16'd0), 1'b1, no_segment(ST_ESTABLISHED));
    add_row(make_event(ACT_SEND_FIN, 16'd0), 1'b1,
            '{1'b1, 32'd1462, 32'd0, FL_FIN | FL_ACK, WINDOW_RESET, 11'd0, ST_FIN_WAIT_1});
    add_row(make_event(ACT_SEND_ACK, 16'd0), 1'b1,
            '{1'b1, 32'd1463, 32'd0, FL_ACK, WINDOW_RESET, 11'd0, ST_FIN_WAIT_1});
    add_row(make_event(ACT_SEND_FIN, 16'd0), 1'b1, no_segment(ST_FIN_WAIT_1));
    add_row(make_event(ACT_OPEN, 16'd0), 1'b1, no_segment(ST_CLOSED));
    add_row(make_event(ACT_SEND_ACK, 16'd0), 1'b1, no_segment(ST_CLOSED));
    add_row(make_event(ACT_SEND_SYN, 16'd0), 1'b0, '0);

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i])
      send_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: setting = '{16'hFFFF, 16'h0000, 16'h0000};
        1: setting = '{16'h0000, 16'hFFFF, 16'hFFFF};
        default: begin
          setting.own_port = 16'($urandom);
          setting.peer_port = 16'($urandom);
          setting.receive_window = 16'($urandom);
        end
      endcase
      write_config(setting);
      gap_pct = gap_plan[phase];
      stall_pct = stall_plan[phase];
      if (phase == 1) hold_request = 1'b1;
      repeat (ITEMS_PER_PHASE) send_event(draw_event(), 1'b0, '0);
    end
    evt_valid <= 1'b0;

    while (expected_segs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
